FILE: hw/rtl/sorted_priority_queue_assert.svh
// ----------------------------------------------------------------------------
// Sorted priority queue assertion macros
// Concurrent checks clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// same-cycle implication
`define SPQ_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sorted_priority_queue check failed");

// next-cycle implication
`define SPQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sorted_priority_queue check failed");

`endif

FILE: hw/rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Transaction types, operation and status codes, cell control types.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int ID_W   = 16;
    localparam int PRIO_W = 16;

    typedef logic [2:0] t_op;
    localparam t_op OP_ENQUEUE = 3'd0;
    localparam t_op OP_DEQUEUE = 3'd1;
    localparam t_op OP_REMOVE  = 3'd2;
    localparam t_op OP_QUERY   = 3'd3;
    localparam t_op OP_PEEK    = 3'd4;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_EMPTY   = 2'd1;
    localparam t_status ST_FULL    = 2'd2;
    localparam t_status ST_NOMATCH = 2'd3;

    typedef logic [1:0] t_cell_mode;
    localparam t_cell_mode CM_HOLD   = 2'd0;
    localparam t_cell_mode CM_INSERT = 2'd1;
    localparam t_cell_mode CM_SHIFT  = 2'd2;

    typedef struct packed {
        t_op               operation;
        logic [ID_W-1:0]   item_id;
        logic [PRIO_W-1:0] item_priority;
        logic [3:0]        item_rank;
    } t_req;

    typedef struct packed {
        logic [ID_W-1:0]   out_id;
        logic [PRIO_W-1:0] out_priority;
        logic              found;
        t_status           status;
        logic [4:0]        entry_count;
    } t_rsp;

    // broadcast to every cell
    typedef struct packed {
        t_cell_mode        mode;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } t_cell_cmd;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } t_entry;

endpackage

FILE: hw/rtl/spq_chan_if.sv
// ----------------------------------------------------------------------------
// Sorted priority queue channel
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface spq_chan_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one entry; inserts, keeps, or takes a neighbor's entry each cycle.
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic               i_clk,
    input  spq_pkg::t_cell_cmd i_cmd,
    input  logic               i_occ,
    input  spq_pkg::t_entry    i_left,
    input  logic               i_left_le,
    input  spq_pkg::t_entry    i_right,
    input  logic               i_take_right,
    output spq_pkg::t_entry    o_entry,
    output logic               o_le,
    output logic               o_match
);

    spq_pkg::t_entry r_entry;
    spq_pkg::t_entry n_entry;

    assign o_entry = r_entry;
    assign o_le    = i_occ && (r_entry.prio <= i_cmd.prio);
    assign o_match = i_occ && (r_entry.id == i_cmd.id);

    always_comb begin
        n_entry = r_entry;
        unique case (i_cmd.mode)
            spq_pkg::CM_INSERT: begin
                if (!i_left_le) begin
                    n_entry = i_left;
                end else if (!o_le) begin
                    n_entry.id   = i_cmd.id;
                    n_entry.prio = i_cmd.prio;
                end
            end
            spq_pkg::CM_SHIFT: begin
                if (i_take_right) begin
                    n_entry = i_right;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

FILE: hw/rtl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// Sorted priority queue
// Bounded (id, priority) queue kept in ascending priority order, ties FIFO.
// ----------------------------------------------------------------------------
// One operation per transaction: enqueue, dequeue, remove by id, query id,
// peek by rank. Entries live in a row of CAPACITY cells, lowest priority at
// cell 0; every cell updates in the cycle the request is taken, comparing
// against the broadcast key and moving data one cell left or right. The
// response appears in the output register on the next cycle; a new request
// is taken every cycle while that register is empty or being drained.
// Entry contents are not cleared by reset; only the count and output valid are.
module sorted_priority_queue #(
    parameter int CAPACITY = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    spq_chan_if.sink        i_req,
    spq_chan_if.source      o_rsp
);

    localparam int CNTW = $clog2(CAPACITY + 1);
    localparam int WIDE = CNTW + 5;

    logic [CNTW-1:0]    r_count;
    logic [CNTW-1:0]    n_count;
    logic               r_rsp_valid;
    logic               n_rsp_valid;
    spq_pkg::t_rsp      r_rsp;
    spq_pkg::t_rsp      n_rsp;

    spq_pkg::t_req      req;
    spq_pkg::t_cell_cmd cmd;
    logic               accept;

    spq_pkg::t_entry    cell_entry [CAPACITY];
    logic [CAPACITY-1:0] occ;
    logic [CAPACITY-1:0] le;
    logic [CAPACITY-1:0] match;
    logic [CAPACITY-1:0] hit_upto;
    logic [CAPACITY-1:0] take_right;
    logic               any_match;
    logic [WIDE-1:0]    rank_ext;
    logic [WIDE-1:0]    count_ext;
    logic [WIDE-1:0]    n_count_ext;
    spq_pkg::t_entry    peek_entry;
    logic               enq_full;
    logic               deq_ok;

    assign req         = i_req.payload;
    assign i_req.ready = !r_rsp_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;
    assign o_rsp.valid   = r_rsp_valid;
    assign o_rsp.payload = r_rsp;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            localparam logic [CAPACITY-1:0] MASK = {CAPACITY{1'b1}} >> (CAPACITY - 1 - g);
            spq_pkg::t_entry left_e;
            spq_pkg::t_entry right_e;
            logic            left_le;

            assign occ[g]      = r_count > CNTW'(g);
            assign hit_upto[g] = |(match & MASK);

            if (g == 0) begin : g_first
                assign left_e  = cell_entry[g];
                assign left_le = 1'b1;
            end else begin : g_mid
                assign left_e  = cell_entry[g-1];
                assign left_le = le[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign right_e = cell_entry[g];
            end else begin : g_inner
                assign right_e = cell_entry[g+1];
            end

            spq_cell u_cell (
                .i_clk        (i_clk),
                .i_cmd        (cmd),
                .i_occ        (occ[g]),
                .i_left       (left_e),
                .i_left_le    (left_le),
                .i_right      (right_e),
                .i_take_right (take_right[g]),
                .o_entry      (cell_entry[g]),
                .o_le         (le[g]),
                .o_match      (match[g])
            );
        end
    endgenerate

    assign any_match   = |match;
    assign rank_ext    = WIDE'(req.item_rank);
    assign count_ext   = WIDE'(r_count);
    assign n_count_ext = WIDE'(n_count);

    always_comb begin
        peek_entry = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (rank_ext == WIDE'(i)) begin
                peek_entry = peek_entry | cell_entry[i];
            end
        end
    end

    always_comb begin
        n_count     = r_count;
        n_rsp_valid = r_rsp_valid && !o_rsp.ready;
        n_rsp       = r_rsp;
        cmd.mode    = spq_pkg::CM_HOLD;
        cmd.id      = req.item_id;
        cmd.prio    = req.item_priority;
        take_right  = '0;
        if (accept) begin
            n_rsp_valid        = 1'b1;
            n_rsp.out_id       = '0;
            n_rsp.out_priority = '0;
            n_rsp.found        = 1'b0;
            n_rsp.status       = spq_pkg::ST_OK;
            unique case (req.operation)
                spq_pkg::OP_ENQUEUE: begin
                    if (r_count == CNTW'(CAPACITY)) begin
                        n_rsp.status = spq_pkg::ST_FULL;
                    end else begin
                        cmd.mode = spq_pkg::CM_INSERT;
                        n_count  = r_count + CNTW'(1);
                    end
                end
                spq_pkg::OP_DEQUEUE: begin
                    if (r_count == '0) begin
                        n_rsp.status = spq_pkg::ST_EMPTY;
                    end else begin
                        cmd.mode           = spq_pkg::CM_SHIFT;
                        take_right         = '1;
                        n_rsp.out_id       = cell_entry[0].id;
                        n_rsp.out_priority = cell_entry[0].prio;
                        n_rsp.found        = 1'b1;
                        n_count            = r_count - CNTW'(1);
                    end
                end
                spq_pkg::OP_REMOVE: begin
                    if (r_count == '0) begin
                        n_rsp.status = spq_pkg::ST_EMPTY;
                    end else if (any_match) begin
                        cmd.mode    = spq_pkg::CM_SHIFT;
                        take_right  = hit_upto;
                        n_rsp.found = 1'b1;
                        n_count     = r_count - CNTW'(1);
                    end else begin
                        n_rsp.status = spq_pkg::ST_NOMATCH;
                    end
                end
                spq_pkg::OP_QUERY: begin
                    if (r_count == '0) begin
                        n_rsp.status = spq_pkg::ST_EMPTY;
                    end else if (any_match) begin
                        n_rsp.found = 1'b1;
                    end else begin
                        n_rsp.status = spq_pkg::ST_NOMATCH;
                    end
                end
                spq_pkg::OP_PEEK: begin
                    if (r_count == '0) begin
                        n_rsp.status = spq_pkg::ST_EMPTY;
                    end else if (rank_ext < count_ext) begin
                        n_rsp.out_id       = peek_entry.id;
                        n_rsp.out_priority = peek_entry.prio;
                        n_rsp.found        = 1'b1;
                    end else begin
                        n_rsp.status = spq_pkg::ST_NOMATCH;
                    end
                end
                default: ;
            endcase
            n_rsp.entry_count = n_count_ext[4:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_rsp_valid <= n_rsp_valid;
        end
        r_rsp <= n_rsp;
    end

    assign enq_full = accept && (req.operation == spq_pkg::OP_ENQUEUE)
                      && (r_count == CNTW'(CAPACITY));
    assign deq_ok   = accept && (req.operation == spq_pkg::OP_DEQUEUE)
                      && (r_count != '0);

`include "sorted_priority_queue_assert.svh"

    `SPQ_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CNTW'(CAPACITY))
    `SPQ_ASSERT_NEXT(a_full_holds, enq_full, $stable(r_count))
    `SPQ_ASSERT_NEXT(a_deq_dec, deq_ok, r_count == $past(r_count) - CNTW'(1))
    `SPQ_ASSERT_NOW(a_found_ok, r_rsp_valid && r_rsp.found, r_rsp.status == spq_pkg::ST_OK)

endmodule

FILE: verif/tb_sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// Sorted priority queue testbench
// Drives enqueue, dequeue, remove, query and peek transactions through the
// request channel, predicts each response with a shadow copy of the sorted
// store, and checks every response field in order. Directed cases cover the
// empty and full queue, ties, id misses and ranks past the count; random
// traffic then moves the fill level across the whole range under three
// back-pressure profiles.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY    = 16;
    localparam int CYCLE_LIMIT = 200000;

    logic i_clk;
    logic i_rst_n;

    spq_chan_if #(.t_payload(spq_pkg::t_req)) req_if ();
    spq_chan_if #(.t_payload(spq_pkg::t_rsp)) rsp_if ();

    sorted_priority_queue #(
        .CAPACITY(CAPACITY)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // shadow of the sorted store
    spq_pkg::t_entry shadow_entries [CAPACITY];
    int     shadow_count;

    spq_pkg::t_rsp pending_responses [$];
    int     error_count = 0;
    int     cycle_count = 0;
    int     send_idle_pct;
    int     recv_idle_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic spq_pkg::t_rsp apply_queue_op(spq_pkg::t_req r);
        spq_pkg::t_rsp rsp;
        int   pos;
        bit   hit;
        rsp  = '0;
        pos  = 0;
        hit  = 1'b0;
        if (r.operation == spq_pkg::OP_ENQUEUE) begin
            if (shadow_count >= CAPACITY) begin
                rsp.status = spq_pkg::ST_FULL;
            end else begin
                while (pos < shadow_count && shadow_entries[pos].prio <= r.item_priority)
                    pos++;
                for (int i = shadow_count; i > pos; i--)
                    shadow_entries[i] = shadow_entries[i-1];
                shadow_entries[pos].id   = r.item_id;
                shadow_entries[pos].prio = r.item_priority;
                shadow_count++;
            end
        end else if (r.operation >= spq_pkg::OP_DEQUEUE && r.operation <= spq_pkg::OP_PEEK
                     && shadow_count == 0) begin
            rsp.status = spq_pkg::ST_EMPTY;
        end else if (r.operation == spq_pkg::OP_DEQUEUE) begin
            rsp.out_id       = shadow_entries[0].id;
            rsp.out_priority = shadow_entries[0].prio;
            rsp.found        = 1'b1;
            for (int i = 0; i + 1 < shadow_count; i++)
                shadow_entries[i] = shadow_entries[i+1];
            shadow_count--;
        end else if (r.operation == spq_pkg::OP_REMOVE
                     || r.operation == spq_pkg::OP_QUERY) begin
            while (pos < shadow_count && !hit) begin
                if (shadow_entries[pos].id == r.item_id)
                    hit = 1'b1;
                else
                    pos++;
            end
            if (!hit) begin
                rsp.status = spq_pkg::ST_NOMATCH;
            end else begin
                rsp.found = 1'b1;
                if (r.operation == spq_pkg::OP_REMOVE) begin
                    for (int i = pos; i + 1 < shadow_count; i++)
                        shadow_entries[i] = shadow_entries[i+1];
                    shadow_count--;
                end
            end
        end else if (r.operation == spq_pkg::OP_PEEK) begin
            if (r.item_rank < shadow_count) begin
                rsp.out_id       = shadow_entries[r.item_rank].id;
                rsp.out_priority = shadow_entries[r.item_rank].prio;
                rsp.found        = 1'b1;
            end else begin
                rsp.status = spq_pkg::ST_NOMATCH;
            end
        end
        rsp.entry_count = shadow_count[4:0];
        return rsp;
    endfunction

    task automatic send_request(input spq_pkg::t_req r);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.payload <= r;
        do
            @(posedge i_clk);
        while (!req_if.ready);
        pending_responses.push_back(apply_queue_op(r));
    endtask

    task automatic send_op(input spq_pkg::t_op op, input int id, input int prio,
                           input int rank);
        spq_pkg::t_req r;
        r.operation     = op;
        r.item_id       = id[15:0];
        r.item_priority = prio[15:0];
        r.item_rank     = rank[3:0];
        send_request(r);
    endtask

    task automatic wait_all_responses();
        req_if.valid <= 1'b0;
        wait (pending_responses.size() == 0);
        @(posedge i_clk);
    endtask

    function automatic void compare_field(string name, int exp_val, int act_val);
        if (exp_val != act_val) begin
            $error("%s expected 0x%0h actual 0x%0h", name, exp_val, act_val);
            error_count++;
        end
    endfunction

    // response checker and receiver back-pressure
    always @(posedge i_clk) begin
        spq_pkg::t_rsp exp_rsp;
        spq_pkg::t_rsp act_rsp;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            act_rsp = rsp_if.payload;
            if (pending_responses.size() == 0) begin
                $error("unexpected response transaction 0x%0h", act_rsp);
                error_count++;
            end else begin
                exp_rsp = pending_responses.pop_front();
                compare_field("out_id", exp_rsp.out_id, act_rsp.out_id);
                compare_field("out_priority", exp_rsp.out_priority, act_rsp.out_priority);
                compare_field("found", exp_rsp.found, act_rsp.found);
                compare_field("status", exp_rsp.status, act_rsp.status);
                compare_field("entry_count", exp_rsp.entry_count, act_rsp.entry_count);
            end
        end
        rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[sorted_priority_queue] ERROR");
            $finish;
        end
    end

    task automatic test_empty_queue();
        send_op(spq_pkg::OP_DEQUEUE, 16'h1234, 0, 0);
        send_op(spq_pkg::OP_REMOVE, 16'h0001, 0, 0);
        send_op(spq_pkg::OP_QUERY, 16'h0001, 0, 0);
        send_op(spq_pkg::OP_PEEK, 0, 0, 0);
        send_op(spq_pkg::t_op'(5), 16'hFFFF, 16'hFFFF, 15);
        send_op(spq_pkg::t_op'(6), 16'hAAAA, 16'h5555, 10);
        send_op(spq_pkg::t_op'(7), 0, 0, 5);
    endtask

    task automatic test_fill_ties_and_full();
        send_op(spq_pkg::OP_ENQUEUE, 16'hFFFF, 16'hFFFF, 0);
        send_op(spq_pkg::OP_ENQUEUE, 16'h0000, 16'h0000, 0);
        for (int i = 0; i < 4; i++)
            send_op(spq_pkg::OP_ENQUEUE, 16'h0100 + i, 16'h0005, 0);
        for (int i = 0; i < 10; i++)
            send_op(spq_pkg::OP_ENQUEUE, 16'h0200 + i, $urandom_range(16'hFFFF), 0);
        send_op(spq_pkg::OP_ENQUEUE, 16'hBEEF, 16'h0003, 0);
        send_op(spq_pkg::OP_PEEK, 0, 0, 15);
        send_op(spq_pkg::OP_QUERY, 16'h0102, 0, 0);
        send_op(spq_pkg::OP_QUERY, 16'hDEAD, 0, 0);
        send_op(spq_pkg::OP_REMOVE, 16'h0101, 0, 0);
        send_op(spq_pkg::OP_REMOVE, 16'hDEAD, 0, 0);
        send_op(spq_pkg::OP_PEEK, 0, 0, 15);
        send_op(spq_pkg::OP_DEQUEUE, 0, 0, 0);
    endtask

    task automatic test_random_traffic(input int n_items);
        spq_pkg::t_req r;
        int   enq_weight;
        int   pick;
        enq_weight = 50;
        for (int n = 0; n < n_items; n++) begin
            if (n % 64 == 0) begin
                case ($urandom_range(2))
                    0:       enq_weight = 25;
                    1:       enq_weight = 50;
                    default: enq_weight = 75;
                endcase
            end
            if ($urandom_range(99) < enq_weight) begin
                r.operation = spq_pkg::OP_ENQUEUE;
            end else begin
                pick = $urandom_range(19);
                if (pick < 6)       r.operation = spq_pkg::OP_DEQUEUE;
                else if (pick < 10) r.operation = spq_pkg::OP_REMOVE;
                else if (pick < 14) r.operation = spq_pkg::OP_QUERY;
                else if (pick < 19) r.operation = spq_pkg::OP_PEEK;
                else                r.operation = spq_pkg::t_op'($urandom_range(7, 5));
            end
            case ($urandom_range(3))
                0:       r.item_id = 16'($urandom);
                1, 2:    r.item_id = 16'($urandom_range(15));
                default: r.item_id = (shadow_count > 0) ?
                             shadow_entries[$urandom_range(shadow_count - 1)].id
                             : 16'($urandom);
            endcase
            r.item_priority = $urandom_range(1) ? 16'($urandom_range(7)) : 16'($urandom);
            r.item_rank     = 4'($urandom_range(15));
            send_request(r);
        end
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        req_if.valid   <= 1'b0;
        req_if.payload <= '0;
        shadow_count   = 0;
        send_idle_pct  = 27;
        recv_idle_pct  = 45;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_queue();
        test_fill_ties_and_full();
        test_random_traffic(700);
        wait_all_responses();

        send_idle_pct = 45;
        recv_idle_pct = 27;
        test_random_traffic(700);
        wait_all_responses();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(600);
        wait_all_responses();

        repeat (5) @(posedge i_clk);
        if (error_count == 0 && pending_responses.size() == 0) begin
            $display("[sorted_priority_queue] OK");
        end else begin
            $display("[sorted_priority_queue] ERROR");
        end
        $finish;
    end

endmodule
